[hw/rtl/three_term_clenshaw_eval_defines.svh]
// Assertion macros for the three-term Clenshaw evaluator.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef THREE_TERM_CLENSHAW_EVAL_DEFINES_SVH
`define THREE_TERM_CLENSHAW_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define TTCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define TTCE_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTCE_ASSERT(lbl, clk, rst, prop, msg)
`define TTCE_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[hw/rtl/ttce_pkg.sv]
// Package for the three-term Clenshaw evaluator: sizes, register map and
// Q16.16 saturating helpers. No dependencies.
`default_nettype none

package ttce_pkg;

   localparam int MAX_TERMS = 64;
   localparam int FRAC_BITS = 16;

   localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CIDX_W = $clog2(MAX_TERMS + 1);
   localparam int CNT_W  = CIDX_W;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_TERM_COUNT = 1'b0;

   localparam logic [0:0] OP_LOAD = 1'b0;
   localparam logic [0:0] OP_EVAL = 1'b1;

   localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;
   localparam logic signed [63:0] Q_MAX64 = 64'sh000000007fffffff;
   localparam logic signed [63:0] Q_MIN64 = 64'shffffffff80000000;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } qsat_type;

   // product -> arithmetic shift (floor) -> saturate
   function automatic qsat_type q_scale(input logic signed [63:0] prod);
      logic signed [63:0] sh;
      qsat_type           r;
      sh = prod >>> FRAC_BITS;
      if (sh > Q_MAX64) begin
         r.ovf = 1'b1;
         r.val = Q_MAX;
      end else if (sh < Q_MIN64) begin
         r.ovf = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.ovf = 1'b0;
         r.val = sh[31:0];
      end
      return r;
   endfunction

   function automatic qsat_type q_sat33(input logic signed [32:0] s);
      qsat_type r;
      r.ovf = (s[32] != s[31]);
      if (r.ovf) begin
         r.val = s[32] ? Q_MIN : Q_MAX;
      end else begin
         r.val = s[31:0];
      end
      return r;
   endfunction

   function automatic qsat_type q_add(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return q_sat33(s);
   endfunction

   function automatic qsat_type q_sub(input logic signed [31:0] a,
                                      input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      return q_sat33(s);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/three_term_clenshaw_eval.sv]
// Three-term Clenshaw evaluator: coefficient/recurrence tables, one shared
// 32x32 multiplier and the term sequencer. Uses ttce_pkg and the defines header.
//
//   channel   ports          handshake                    payload
//   request   req_*          start & !busy                opcode, index, values, x, phi0
//   result    rsp_*          rsp_valid, one cycle          sum, overflow, last
//   config    APB            psel & penable & pwrite       term_count at 0x0
//
// A load writes the tables directly; busy stays low. An evaluate with n terms
// holds busy while each term steps through MUL_A, MUL_C, MUL_T, DIFF and ACC,
// then MUL_W and OUT; the result strobe follows in the next cycle. With n = 0 it
// comes in the cycle after start. The single multiplier forms A*x, C*bk2, t*bk1 in turn.
// Reset clears the sequencer, term_count and the strobe; tables are undefined.
// The receiver cannot stall; a new start is taken while the strobe is high.
`default_nettype none

`include "three_term_clenshaw_eval_defines.svh"

module three_term_clenshaw_eval
   import ttce_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_opcode,
   input  wire logic [6:0]              req_entry_index,
   input  wire logic signed [31:0]      req_coef_value,
   input  wire logic signed [31:0]      req_rec_a,
   input  wire logic signed [31:0]      req_rec_b,
   input  wire logic signed [31:0]      req_rec_c,
   input  wire logic signed [31:0]      req_point_x,
   input  wire logic signed [31:0]      req_weight_phi0,
   input  wire logic                    req_last_point,
   // result channel
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_sum_value,
   output logic                         rsp_overflow,
   output logic                         rsp_last_result,
   // APB
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL_A = 8'b0000_0010,
      ST_MUL_C = 8'b0000_0100,
      ST_MUL_T = 8'b0000_1000,
      ST_DIFF  = 8'b0001_0000,
      ST_ACC   = 8'b0010_0000,
      ST_MUL_W = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]          term_count_ff, term_count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic signed [31:0]  x_ff, x_in;
   logic signed [31:0]  phi0_ff, phi0_in;
   logic                last_ff, last_in;
   logic signed [31:0]  bk1_ff, bk1_in;
   logic signed [31:0]  bk2_ff, bk2_in;
   logic signed [31:0]  t_ff, t_in;
   logic signed [31:0]  v_ff, v_in;
   logic signed [31:0]  w_ff, w_in;
   logic signed [31:0]  coef_hold_ff, coef_hold_in;
   logic                ovf_ff, ovf_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [31:0]  mul_a, mul_b;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_sum_ff, rsp_sum_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   // table memories
   logic signed [31:0]  coef_mem [MAX_TERMS];
   logic signed [31:0]  a_mem    [MAX_TERMS];
   logic signed [31:0]  b_mem    [MAX_TERMS];
   logic signed [31:0]  c_mem    [MAX_TERMS+1];
   logic signed [31:0]  coef_rd_ff, a_rd_ff, b_rd_ff, c_rd_ff;

   logic                acc_req, eval_req, load_req;
   logic                tab_wr, c_wr, rd_en, csr_wr;
   logic [IDX_W-1:0]    wr_idx, rd_idx;
   logic [CIDX_W-1:0]   wr_cidx, rd_cidx;
   logic [CNT_W-1:0]    n_terms;
   qsat_type            q_prod, s_t, s_w, s_bk;

   assign busy     = (state_ff != ST_IDLE);
   assign acc_req  = start && !busy;
   assign eval_req = acc_req && (req_opcode == OP_EVAL);
   assign load_req = acc_req && (req_opcode == OP_LOAD);

   // load decode: index MAX_TERMS writes only the C term
   assign tab_wr  = load_req && (32'(req_entry_index) < MAX_TERMS);
   assign c_wr    = load_req && (32'(req_entry_index) <= MAX_TERMS);
   assign wr_idx  = IDX_W'(req_entry_index);
   assign wr_cidx = CIDX_W'(req_entry_index);

   always_comb begin
      if (32'(term_count_ff) > MAX_TERMS) begin
         n_terms = CNT_W'(MAX_TERMS);
      end else begin
         n_terms = CNT_W'(term_count_ff);
      end
   end

   // C is read one entry above the other tables
   always_comb begin
      rd_en   = 1'b0;
      rd_idx  = idx_ff - IDX_W'(1);
      rd_cidx = CIDX_W'(idx_ff);
      if (eval_req) begin
         rd_en   = (n_terms != '0);
         rd_idx  = IDX_W'(n_terms - CNT_W'(1));
         rd_cidx = CIDX_W'(n_terms);
      end else if (state_ff == ST_DIFF) begin
         rd_en = (idx_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (tab_wr) begin
         coef_mem[wr_idx] <= req_coef_value;
         a_mem[wr_idx]    <= req_rec_a;
         b_mem[wr_idx]    <= req_rec_b;
      end
      if (c_wr) begin
         c_mem[wr_cidx] <= req_rec_c;
      end
      if (rd_en) begin
         coef_rd_ff <= coef_mem[rd_idx];
         a_rd_ff    <= a_mem[rd_idx];
         b_rd_ff    <= b_mem[rd_idx];
         c_rd_ff    <= c_mem[rd_cidx];
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_TERM_COUNT);
   assign term_count_in = csr_wr ? pwdata[6:0] : term_count_ff;
   assign prdata = (paddr[2] == CSR_TERM_COUNT) ? 32'(term_count_ff) : '0;

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_A: begin
            mul_a = a_rd_ff;
            mul_b = x_ff;
         end
         ST_MUL_C: begin
            mul_a = c_rd_ff;
            mul_b = bk2_ff;
         end
         ST_MUL_T: begin
            mul_a = t_ff;
            mul_b = bk1_ff;
         end
         ST_MUL_W: begin
            mul_a = phi0_ff;
            mul_b = bk1_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign q_prod  = q_scale(prod_ff);
   assign s_t     = q_add(q_prod.val, b_rd_ff);
   assign s_w     = q_sub(q_prod.val, v_ff);
   assign s_bk    = q_add(w_ff, coef_hold_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      phi0_in      = phi0_ff;
      last_in      = last_ff;
      bk1_in       = bk1_ff;
      bk2_in       = bk2_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      coef_hold_in = coef_hold_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (eval_req) begin
               x_in    = req_point_x;
               phi0_in = req_weight_phi0;
               last_in = req_last_point;
               bk1_in  = '0;
               bk2_in  = '0;
               ovf_in  = 1'b0;
               idx_in  = IDX_W'(n_terms - CNT_W'(1));
               if (n_terms == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = '0;
                  rsp_ovf_in   = 1'b0;
                  rsp_last_in  = req_last_point;
               end else begin
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            t_in     = s_t.val;
            ovf_in   = ovf_ff | q_prod.ovf | s_t.ovf;
            state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            v_in         = q_prod.val;
            ovf_in       = ovf_ff | q_prod.ovf;
            coef_hold_in = coef_rd_ff;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            w_in     = s_w.val;
            ovf_in   = ovf_ff | q_prod.ovf | s_w.ovf;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            bk1_in = s_bk.val;
            bk2_in = bk1_ff;
            ovf_in = ovf_ff | s_bk.ovf;
            if (idx_ff == '0) begin
               state_in = ST_MUL_W;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_W: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_sum_in   = q_prod.val;
            rsp_ovf_in   = ovf_ff | q_prod.ovf;
            rsp_last_in  = last_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         term_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         term_count_ff <= term_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      x_ff         <= x_in;
      phi0_ff      <= phi0_in;
      last_ff      <= last_in;
      bk1_ff       <= bk1_in;
      bk2_ff       <= bk2_in;
      t_ff         <= t_in;
      v_ff         <= v_in;
      w_ff         <= w_in;
      coef_hold_ff <= coef_hold_in;
      prod_ff      <= prod_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_value   = rsp_sum_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last_result = rsp_last_ff;

   `TTCE_ASSERT(a_out_strobe, clock, reset, (state_ff == ST_OUT) |=> rsp_valid_ff, "no strobe after final stage")
   `TTCE_ASSERT(a_quiet_busy, clock, reset, busy |-> !rsp_valid_ff, "result strobe while evaluating")
   `TTCE_ASSERT(a_last_term, clock, reset, (state_ff == ST_ACC && idx_ff == '0) |=> (state_ff == ST_MUL_W), "final term did not end the loop")
   `TTCE_ASSERT(a_ovf_sticky, clock, reset, (busy && $past(busy) && $past(ovf_ff)) |-> ovf_ff, "overflow flag dropped mid-evaluation")
   `TTCE_ASSERT_NR(a_reset_idle, clock, $past(reset) |-> (state_ff == ST_IDLE && !rsp_valid_ff), "not idle after reset")

endmodule

`default_nettype wire

[test/tb_three_term_clenshaw_eval.sv]
`timescale 1ns / 100ps
// Testbench for three_term_clenshaw_eval: table loads and Clenshaw evaluations checked
// against a Q16.16 scoreboard. Depends on ttce_pkg and the RTL of the evaluator.

module tb_three_term_clenshaw_eval
   import ttce_pkg::*;
;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 125;
   localparam logic [CSR_ADDR_W-1:0] TERM_COUNT_ADDR = CSR_ADDR_W'(4 * CSR_TERM_COUNT);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4 * (CSR_TERM_COUNT + 1));

   typedef struct {
      logic [0:0]         opcode;
      logic [6:0]         index;
      logic signed [31:0] coef;
      logic signed [31:0] rec_a;
      logic signed [31:0] rec_b;
      logic signed [31:0] rec_c;
      logic signed [31:0] x;
      logic signed [31:0] phi0;
      logic               last;
   } clen_request_type;

   typedef struct {
      logic signed [31:0] sum;
      logic               ovf;
      logic               last;
   } clen_sum_type;

   // Holds the expansion tables, predicts each evaluation and checks the sums in order.
   class clenshaw_scoreboard;
      logic signed [31:0] coef_mem[MAX_TERMS];
      logic signed [31:0] a_mem[MAX_TERMS];
      logic signed [31:0] b_mem[MAX_TERMS];
      logic signed [31:0] c_mem[MAX_TERMS + 1];
      int unsigned        terms;
      clen_sum_type       pending_sums[$];
      int                 errors;
      bit                 step_ovf;

      function new();
         terms = 0;
         errors = 0;
         step_ovf = 1'b0;
      endfunction

      function void set_terms(logic [6:0] value);
         terms = value;
      endfunction

      // saturation marks step_ovf for the evaluation in progress
      function longint clamp(longint v);
         if (v > longint'(Q_MAX)) begin
            step_ovf = 1'b1;
            return longint'(Q_MAX);
         end
         if (v < longint'(Q_MIN)) begin
            step_ovf = 1'b1;
            return longint'(Q_MIN);
         end
         return v;
      endfunction

      // exact product, floor shift, then saturate
      function longint scale_mul(longint a, longint b);
         return clamp((a * b) >>> FRAC_BITS);
      endfunction

      function void note_request(clen_request_type rq);
         int unsigned  n;
         int unsigned  j;
         longint       bk, bk1, bk2, t, u, v, w, res;
         clen_sum_type exp_sum;
         if (rq.opcode == OP_LOAD) begin
            if (rq.index < MAX_TERMS) begin
               coef_mem[rq.index] = rq.coef;
               a_mem[rq.index] = rq.rec_a;
               b_mem[rq.index] = rq.rec_b;
               c_mem[rq.index] = rq.rec_c;
            end else if (rq.index == MAX_TERMS) begin
               c_mem[MAX_TERMS] = rq.rec_c;
            end
            return;
         end
         n = (terms > MAX_TERMS) ? MAX_TERMS : terms;
         bk = 0;
         bk1 = 0;
         bk2 = 0;
         res = 0;
         step_ovf = 1'b0;
         for (int unsigned i = n; i > 0; i--) begin
            j = i - 1;
            t = scale_mul(a_mem[j], rq.x);
            t = clamp(t + longint'(b_mem[j]));
            u = scale_mul(t, bk1);
            v = scale_mul(c_mem[j + 1], bk2);
            w = clamp(u - v);
            bk = clamp(w + longint'(coef_mem[j]));
            bk2 = bk1;
            bk1 = bk;
         end
         if (n >= 1) begin
            res = scale_mul(rq.phi0, bk);
         end
         exp_sum.sum = res[31:0];
         exp_sum.ovf = step_ovf;
         exp_sum.last = rq.last;
         pending_sums.push_back(exp_sum);
      endfunction

      task report(string msg);
         errors++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_result(clen_sum_type got);
         clen_sum_type want;
         if (pending_sums.size() == 0) begin
            report($sformatf("unexpected result sum=%h", got.sum));
            return;
         end
         want = pending_sums.pop_front();
         if (got.sum !== want.sum) begin
            report($sformatf("sum_value got %h want %h", got.sum, want.sum));
         end
         if (got.ovf !== want.ovf) begin
            report($sformatf("overflow got %b want %b", got.ovf, want.ovf));
         end
         if (got.last !== want.last) begin
            report($sformatf("last_result got %b want %b", got.last, want.last));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_opcode;
   logic [6:0]            req_entry_index;
   logic signed [31:0]    req_coef_value;
   logic signed [31:0]    req_rec_a;
   logic signed [31:0]    req_rec_b;
   logic signed [31:0]    req_rec_c;
   logic signed [31:0]    req_point_x;
   logic signed [31:0]    req_weight_phi0;
   logic                  req_last_point;
   logic                  rsp_valid;
   logic signed [31:0]    rsp_sum_value;
   logic                  rsp_overflow;
   logic                  rsp_last_result;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   clenshaw_scoreboard    sb;
   bit                    full_written[MAX_TERMS];
   bit                    c_written[MAX_TERMS + 1];
   int unsigned           cur_terms;
   int                    stall_cycles;

   three_term_clenshaw_eval i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_coef_value  (req_coef_value),
      .req_rec_a       (req_rec_a),
      .req_rec_b       (req_rec_b),
      .req_rec_c       (req_rec_c),
      .req_point_x     (req_point_x),
      .req_weight_phi0 (req_weight_phi0),
      .req_last_point  (req_last_point),
      .rsp_valid       (rsp_valid),
      .rsp_sum_value   (rsp_sum_value),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor and no-progress watchdog
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if (rsp_valid) begin
            sb.check_result('{rsp_sum_value, rsp_overflow, rsp_last_result});
         end
         if ((start && !busy) || rsp_valid || (psel && penable && pready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_q();
      int unsigned sel;
      sel = $urandom_range(15);
      case (sel)
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'sd0;
         3, 4: return $urandom;
         5, 6: return 32'($urandom_range(262143)) - 32'd131072;
         default: return 32'($urandom_range(65535)) - 32'd32768;
      endcase
   endfunction

   function automatic clen_request_type make_load(int unsigned idx, logic signed [31:0] coef,
                                                  logic signed [31:0] ra,
                                                  logic signed [31:0] rb,
                                                  logic signed [31:0] rc);
      clen_request_type rq;
      rq.opcode = OP_LOAD;
      rq.index = 7'(idx);
      rq.coef = coef;
      rq.rec_a = ra;
      rq.rec_b = rb;
      rq.rec_c = rc;
      rq.x = rand_q();
      rq.phi0 = rand_q();
      rq.last = 1'($urandom_range(1));
      return rq;
   endfunction

   function automatic clen_request_type make_eval(logic signed [31:0] x,
                                                  logic signed [31:0] phi0, logic last);
      clen_request_type rq;
      rq.opcode = OP_EVAL;
      rq.index = 7'($urandom_range(127));
      rq.coef = rand_q();
      rq.rec_a = rand_q();
      rq.rec_b = rand_q();
      rq.rec_c = rand_q();
      rq.x = x;
      rq.phi0 = phi0;
      rq.last = last;
      return rq;
   endfunction

   // first table entry an evaluation would read before it is written, or -1
   function automatic int missing_entry();
      int unsigned n;
      n = (cur_terms > MAX_TERMS) ? MAX_TERMS : cur_terms;
      for (int unsigned j = 0; j < n; j++) begin
         if (!full_written[j]) begin
            return j;
         end
      end
      if (n >= 1 && !c_written[n]) begin
         return n;
      end
      return -1;
   endfunction

   task automatic send_request(clen_request_type rq);
      @(negedge clock);
      req_opcode = rq.opcode;
      req_entry_index = rq.index;
      req_coef_value = rq.coef;
      req_rec_a = rq.rec_a;
      req_rec_b = rq.rec_b;
      req_rec_c = rq.rec_c;
      req_point_x = rq.x;
      req_weight_phi0 = rq.phi0;
      req_last_point = rq.last;
      start = 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(rq);
      if (rq.opcode == OP_LOAD) begin
         if (rq.index < MAX_TERMS) begin
            full_written[rq.index] = 1'b1;
            c_written[rq.index] = 1'b1;
         end else if (rq.index == MAX_TERMS) begin
            c_written[MAX_TERMS] = 1'b1;
         end
      end
   endtask

   task automatic idle_sender();
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain_results();
      idle_sender();
      while (sb.pending_sums.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      if (addr == TERM_COUNT_ADDR) begin
         sb.set_terms(data[6:0]);
         cur_terms = data[6:0];
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic settle_and_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      drain_results();
      // idle margin before the register write
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(addr, data);
   endtask

   task automatic run_random_phase(int unsigned terms, int unsigned idle_pct);
      clen_request_type rq;
      int               gap;
      int unsigned      pick;
      settle_and_write(TERM_COUNT_ADDR, terms);
      for (int item = 0; item < PHASE_ITEMS; item++) begin
         while ($urandom_range(99) < idle_pct) begin
            idle_sender();
         end
         if ($urandom_range(59) == 0) begin
            drain_results();
         end
         pick = $urandom_range(99);
         gap = missing_entry();
         if (pick < 55 && gap >= 0) begin
            // evaluation would read an unwritten entry: fill it first
            rq = make_load(gap, rand_q(), rand_q(), rand_q(), rand_q());
         end else if (pick < 55) begin
            rq = make_eval(rand_q(), rand_q(), 1'($urandom_range(1)));
         end else if (pick < 93) begin
            rq = make_load($urandom_range(MAX_TERMS - 1), rand_q(), rand_q(), rand_q(),
                           rand_q());
         end else if (pick < 96) begin
            rq = make_load(MAX_TERMS, rand_q(), rand_q(), rand_q(), rand_q());
         end else begin
            rq = make_load($urandom_range(127, MAX_TERMS + 1), rand_q(), rand_q(), rand_q(),
                           rand_q());
         end
         send_request(rq);
      end
   endtask

   initial begin
      sb = new();
      cur_terms = 0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_LOAD;
      req_entry_index = '0;
      req_coef_value = '0;
      req_rec_a = '0;
      req_rec_b = '0;
      req_rec_c = '0;
      req_point_x = '0;
      req_weight_phi0 = '0;
      req_last_point = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // no terms after reset: sum is zero whatever the point
      send_request(make_eval(Q_MAX, Q_MAX, 1'b1));
      send_request(make_eval(Q_MIN, Q_MIN, 1'b0));
      send_request(make_load(0, 32'sh00010000, 32'sh00010000, 32'sh0, Q_MIN));
      send_request(make_load(1, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
      send_request(make_load(2, -32'sd1, 32'sh0, -32'sd1, 32'sh0));
      send_request(make_load(3, 32'sh00008000, 32'shffff0000, 32'sh00020000, 32'sh00018000));
      send_request(make_load(MAX_TERMS, 32'shffffffff, 32'shffffffff, 32'shffffffff,
                             32'sh00008000));
      // indices past the C-only entry are dropped
      send_request(make_load(MAX_TERMS + 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      send_request(make_load(127, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      send_request(make_load(MAX_TERMS - 1, 32'sh7fff0000, 32'sh00000001, 32'sh80000001,
                             32'sh55555555));

      settle_and_write(TERM_COUNT_ADDR, 32'd3);
      // unmapped register: term count must stay at three
      csr_write(UNMAPPED_ADDR, 32'hffffffff);
      send_request(make_eval(32'sh0, 32'sh00010000, 1'b0));
      send_request(make_eval(Q_MAX, Q_MAX, 1'b1));
      send_request(make_eval(Q_MIN, Q_MIN, 1'b0));
      send_request(make_eval(-32'sd1, -32'sd1, 1'b1));
      drain_results();
      send_request(make_load(1, 32'sh00004000, 32'sh00008000, 32'shffffc000, 32'sh00002000));
      send_request(make_eval(32'sh00010000, 32'sh00000001, 1'b0));
      send_request(make_eval(32'shfffe8000, 32'shffff0000, 1'b1));
      send_request(make_eval(32'sh00007fff, 32'sh7fffffff, 1'b0));

      run_random_phase(1, 10);
      run_random_phase(4, 10);
      run_random_phase(MAX_TERMS, 10);
      run_random_phase(2, 81);
      run_random_phase(127, 81);
      run_random_phase(0, 81);
      run_random_phase(7, 0);
      run_random_phase(MAX_TERMS + 1, 0);
      run_random_phase(12, 0);
      run_random_phase(3, 0);

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ttce_pkg.sv
hw/rtl/three_term_clenshaw_eval.sv
test/tb_three_term_clenshaw_eval.sv
